/* hdl/contact_impulse_resolver_macros.svh */
// Assertion macros for the contact impulse resolver.
// Define ASSERT_OFF to compile every check out.
`ifndef CONTACT_IMPULSE_RESOLVER_MACROS_SVH
`define CONTACT_IMPULSE_RESOLVER_MACROS_SVH
`ifndef ASSERT_OFF
// check at every edge out of reset
`define CIR_ASSERT(lbl, prop, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) prop) else $error(msg);
// check at every edge, reset included
`define CIR_ASSERT_RST(lbl, prop, msg) \
	lbl: assert property (@(posedge clk) prop) else $error(msg);
`else
`define CIR_ASSERT(lbl, prop, msg)
`define CIR_ASSERT_RST(lbl, prop, msg)
`endif
`endif

/* hdl/cir_pkg.sv */
`timescale 1ns / 1ps
`default_nettype none
package cir_pkg;

	// divider geometry
	localparam int unsigned DIV_NW = 64;   // dividend width
	localparam int unsigned DIV_QW = 53;   // quotient width
	localparam int unsigned DIV_DW = 32;   // divisor width

	localparam int unsigned MAG_W  = 48;
	localparam logic [MAG_W-1:0] JMAG_MAX = 48'h8000_0000_0000;

	localparam logic [17:0] ONE_Q16    = 18'h10000;
	localparam logic [15:0] ROUND_HALF = 16'h8000;

	localparam logic [16:0] RESTITUTION_RESET = 17'h08000;
	localparam logic [2:0]  ADDR_RESTITUTION  = 3'd0;

	typedef struct packed {
		logic               v;
		logic               skip;
		logic signed [17:0] nx;
		logic signed [17:0] ny;
	} cir_tag_t;

	// apply sign to a rounded magnitude and clamp to the signed 32 bit range
	function automatic logic [31:0] sat_q16(input logic [49:0] r, input logic s);
		logic [31:0] res;
		if (s) begin
			if (r > 50'h0_8000_0000)
				res = 32'h8000_0000;
			else
				res = ~r[31:0] + 32'd1;
		end else begin
			if (r > 50'h0_7FFF_FFFF)
				res = 32'h7FFF_FFFF;
			else
				res = r[31:0];
		end
		return res;
	endfunction

endpackage
`default_nettype wire

/* hdl/cir_div.sv */
`timescale 1ns / 1ps
`default_nettype none
// Three restoring dividers sharing one divisor, one quotient bit per stage.
module cir_div import cir_pkg::*; (
	input  wire logic              clk,
	input  wire logic              arst_n,
	input  wire logic              en,
	input  wire logic [DIV_NW-1:0] num_a,
	input  wire logic [DIV_NW-1:0] num_b,
	input  wire logic [DIV_NW-1:0] num_j,
	input  wire logic [DIV_DW-1:0] den,
	input  wire cir_tag_t          tag_in,
	output logic [DIV_QW-1:0]      quo_a,
	output logic [DIV_QW-1:0]      quo_b,
	output logic [DIV_QW-1:0]      quo_j,
	output cir_tag_t               tag_out
);

	localparam int unsigned NW = DIV_NW;
	localparam int unsigned QW = DIV_QW;
	localparam int unsigned DW = DIV_DW;

	logic [DW-1:0] rem_s [QW][3];
	logic [QW-1:0] lo_s  [QW][3];
	logic [QW-1:0] q_s   [QW][3];
	logic [DW-1:0] d_s   [QW];
	cir_tag_t      tag_s [QW];
	logic [NW-1:0] num_l [3];

	assign num_l[0] = num_a;
	assign num_l[1] = num_b;
	assign num_l[2] = num_j;

	// shift in one bit, subtract when it fits: {quotient bit, remainder}
	function automatic logic [DW:0] div_step(input logic [DW-1:0] rem, input logic b,
		input logic [DW-1:0] d);
		logic [DW:0] trial;
		logic [DW:0] res;
		trial = {rem, b};
		if (trial >= {1'b0, d})
			res = {1'b1, DW'(trial - {1'b0, d})};
		else
			res = {1'b0, trial[DW-1:0]};
		return res;
	endfunction

	for (genvar k = 0; k < QW; k++) begin : g_stage
		logic [DW-1:0] rem_i [3];
		logic [QW-1:0] lo_i  [3];
		logic [QW-1:0] q_i   [3];
		logic [DW:0]   st    [3];
		logic [DW-1:0] d_i;
		cir_tag_t      t_i;

		if (k == 0) begin : g_first
			assign d_i = den;
			assign t_i = tag_in;
			for (genvar l = 0; l < 3; l++) begin : g_lane
				assign rem_i[l] = DW'(num_l[l][NW-1:QW]);
				assign lo_i[l]  = num_l[l][QW-1:0];
				assign q_i[l]   = '0;
			end
		end else begin : g_next
			assign d_i = d_s[k-1];
			assign t_i = tag_s[k-1];
			for (genvar l = 0; l < 3; l++) begin : g_lane
				assign rem_i[l] = rem_s[k-1][l];
				assign lo_i[l]  = lo_s[k-1][l];
				assign q_i[l]   = q_s[k-1][l];
			end
		end

		for (genvar l = 0; l < 3; l++) begin : g_step
			assign st[l] = div_step(rem_i[l], lo_i[l][QW-1], d_i);

			always_ff @(posedge clk) begin
				if (en) begin
					rem_s[k][l] <= st[l][DW-1:0];
					lo_s[k][l]  <= {lo_i[l][QW-2:0], 1'b0};
					q_s[k][l]   <= {q_i[l][QW-2:0], st[l][DW]};
				end
			end
		end

		always_ff @(posedge clk) begin
			if (en) begin
				d_s[k] <= d_i;
			end
		end

		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n) begin
				tag_s[k] <= '0;
			end else if (en) begin
				tag_s[k] <= t_i;
			end
		end
	end

	assign quo_a   = q_s[QW-1][0];
	assign quo_b   = q_s[QW-1][1];
	assign quo_j   = q_s[QW-1][2];
	assign tag_out = tag_s[QW-1];

endmodule
`default_nettype wire

/* hdl/contact_impulse_resolver.sv */
// Contact impulse resolver: takes one 2D contact word per cycle (body velocities Q16.16,
// inverse masses and penetration depth unsigned Q15.16, contact normal Q2.16) and returns
// the position shifts for both bodies and the restitution impulse, rounded half
// away from zero and saturated to 32 bits. A contact with both inverse masses zero
// comes out flagged as skipped with all other fields zero. The block is a fixed
// pipeline of 63 stages: six front stages form the dividends, 53 stages of a
// bit-per-stage restoring divider produce the quotients, and four back stages do
// the clamp, the split 18x48 products and the saturation. It takes a new word in
// every cycle while the output is not stalled. A stall on the output freezes the
// whole pipe and is passed straight back to in_stall. The restitution register
// sits at byte address 0 and is only to be written while the pipe is empty.
`timescale 1ns / 1ps
`default_nettype none
`include "contact_impulse_resolver_macros.svh"
module contact_impulse_resolver import cir_pkg::*; (
	input  wire logic               clk,
	input  wire logic               arst_n,
	// input word
	input  wire logic               in_valid,
	output logic                    in_stall,
	input  wire logic signed [31:0] vel_a_x,
	input  wire logic signed [31:0] vel_a_y,
	input  wire logic signed [31:0] vel_b_x,
	input  wire logic signed [31:0] vel_b_y,
	input  wire logic [30:0]        inv_mass_a,
	input  wire logic [30:0]        inv_mass_b,
	input  wire logic signed [17:0] normal_x,
	input  wire logic signed [17:0] normal_y,
	input  wire logic [30:0]        depth,
	// result word
	output logic                    out_valid,
	input  wire logic               out_stall,
	output logic signed [31:0]      shift_a_x,
	output logic signed [31:0]      shift_a_y,
	output logic signed [31:0]      shift_b_x,
	output logic signed [31:0]      shift_b_y,
	output logic signed [31:0]      impulse_x,
	output logic signed [31:0]      impulse_y,
	output logic                    skipped,
	// configuration
	input  wire logic               psel,
	input  wire logic               penable,
	input  wire logic               pwrite,
	input  wire logic [2:0]         paddr,
	input  wire logic [31:0]        pwdata,
	output logic [31:0]             prdata,
	output logic                    pready
);

	// advance the whole pipe unless the output word is held
	logic adv;
	assign adv      = !out_valid || !out_stall;
	assign in_stall = !adv;

	// ---------------- configuration ----------------
	logic [16:0] restitution_q;

	assign pready = 1'b1;
	assign prdata = (paddr == ADDR_RESTITUTION) ? 32'(restitution_q) : 32'd0;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			restitution_q <= RESTITUTION_RESET;
		end else if (psel && penable && pwrite && pready && paddr == ADDR_RESTITUTION) begin
			restitution_q <= pwdata[16:0];
		end
	end

	// ---------------- valid chain ----------------
	logic v_s1, v_s2, v_s3, v_s4, v_s5, v_s6, v_s7, v_s8, v_s9, v_s10;
	cir_tag_t dtag;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1  <= 1'b0;
			v_s2  <= 1'b0;
			v_s3  <= 1'b0;
			v_s4  <= 1'b0;
			v_s5  <= 1'b0;
			v_s6  <= 1'b0;
			v_s7  <= 1'b0;
			v_s8  <= 1'b0;
			v_s9  <= 1'b0;
			v_s10 <= 1'b0;
		end else if (adv) begin
			v_s1  <= in_valid;
			v_s2  <= v_s1;
			v_s3  <= v_s2;
			v_s4  <= v_s3;
			v_s5  <= v_s4;
			v_s6  <= v_s5;
			v_s7  <= dtag.v;
			v_s8  <= v_s7;
			v_s9  <= v_s8;
			v_s10 <= v_s9;
		end
	end

	// ---------------- front stages ----------------
	// s1: velocity differences and summed inverse mass
	logic signed [32:0] dvx_s1, dvy_s1;
	logic [31:0]        total_s1;
	logic [30:0]        depth_s1, ima_s1, imb_s1;
	logic signed [17:0] nx_s1, ny_s1;

	// s2: products
	logic [61:0]        pda_s2, pdb_s2;
	logic signed [50:0] pvx_s2, pvy_s2;
	logic [31:0]        total_s2;
	logic signed [17:0] nx_s2, ny_s2;

	// s3: dividends for the shares, normal velocity
	logic [62:0]        na_s3, nb_s3;
	logic signed [51:0] vn_s3;
	logic [31:0]        total_s3;
	logic signed [17:0] nx_s3, ny_s3;

	// s4: approaching speed rounded to Q16.16 (zero when separating)
	logic [51:0]        avn;
	logic [35:0]        vn16_s4;
	logic [62:0]        na_s4, nb_s4;
	logic [31:0]        total_s4;
	logic signed [17:0] nx_s4, ny_s4;

	// s5: impulse numerator
	logic [53:0]        num_s5;
	logic [62:0]        na_s5, nb_s5;
	logic [31:0]        total_s5;
	logic signed [17:0] nx_s5, ny_s5;

	// s6: rounded impulse dividend
	logic [53:0]        nj_s6;
	logic [62:0]        na_s6, nb_s6;
	logic [31:0]        total_s6;
	logic signed [17:0] nx_s6, ny_s6;

	assign avn = vn_s3[51] ? 52'(-vn_s3) : 52'(vn_s3);

	always_ff @(posedge clk) begin
		if (adv) begin
			dvx_s1   <= 33'(vel_b_x) - 33'(vel_a_x);
			dvy_s1   <= 33'(vel_b_y) - 33'(vel_a_y);
			total_s1 <= 32'(inv_mass_a) + 32'(inv_mass_b);
			depth_s1 <= depth;
			ima_s1   <= inv_mass_a;
			imb_s1   <= inv_mass_b;
			nx_s1    <= normal_x;
			ny_s1    <= normal_y;

			pda_s2   <= 62'(depth_s1) * 62'(ima_s1);
			pdb_s2   <= 62'(depth_s1) * 62'(imb_s1);
			pvx_s2   <= 51'(dvx_s1) * 51'(nx_s1);
			pvy_s2   <= 51'(dvy_s1) * 51'(ny_s1);
			total_s2 <= total_s1;
			nx_s2    <= nx_s1;
			ny_s2    <= ny_s1;

			na_s3    <= 63'(pda_s2) + 63'(total_s2[31:1]);
			nb_s3    <= 63'(pdb_s2) + 63'(total_s2[31:1]);
			vn_s3    <= 52'(pvx_s2) + 52'(pvy_s2);
			total_s3 <= total_s2;
			nx_s3    <= nx_s2;
			ny_s3    <= ny_s2;

			vn16_s4  <= vn_s3[51] ? 36'((avn + 52'(ROUND_HALF)) >> 16) : 36'd0;
			na_s4    <= na_s3;
			nb_s4    <= nb_s3;
			total_s4 <= total_s3;
			nx_s4    <= nx_s3;
			ny_s4    <= ny_s3;

			num_s5   <= 54'(ONE_Q16 + 18'(restitution_q)) * 54'(vn16_s4);
			na_s5    <= na_s4;
			nb_s5    <= nb_s4;
			total_s5 <= total_s4;
			nx_s5    <= nx_s4;
			ny_s5    <= ny_s4;

			nj_s6    <= num_s5 + 54'(total_s5[31:1]);
			na_s6    <= na_s5;
			nb_s6    <= nb_s5;
			total_s6 <= total_s5;
			nx_s6    <= nx_s5;
			ny_s6    <= ny_s5;
		end
	end

	// ---------------- division ----------------
	cir_tag_t          tag6;
	logic [DIV_QW-1:0] dq_a, dq_b, dq_j;

	assign tag6.v    = v_s6;
	assign tag6.skip = (total_s6 == 32'd0);
	assign tag6.nx   = nx_s6;
	assign tag6.ny   = ny_s6;

	cir_div u_div (
		.clk     (clk),
		.arst_n  (arst_n),
		.en      (adv),
		.num_a   (DIV_NW'(na_s6)),
		.num_b   (DIV_NW'(nb_s6)),
		.num_j   (DIV_NW'(nj_s6)),
		.den     (total_s6),
		.tag_in  (tag6),
		.quo_a   (dq_a),
		.quo_b   (dq_b),
		.quo_j   (dq_j),
		.tag_out (dtag)
	);

	// ---------------- back stages ----------------
	// lanes: shift_a_x, shift_a_y, shift_b_x, shift_b_y, impulse_x, impulse_y
	logic [MAG_W-1:0]   pa_s7, pb_s7, jm_s7;
	logic               skip_s7, skip_s8, skip_s9, skip_s10;
	logic signed [17:0] nx_s7, ny_s7;
	logic [41:0]        lo_s8 [6];
	logic [41:0]        hi_s8 [6];
	logic               sg_s8 [6];
	logic [49:0]        r_s9  [6];
	logic               sg_s9 [6];
	logic [31:0]        res_s10 [6];

	always_ff @(posedge clk) begin
		if (adv) begin
			// clamp the impulse magnitude; shares always fit below 2^31
			pa_s7    <= MAG_W'(dq_a[30:0]);
			pb_s7    <= MAG_W'(dq_b[30:0]);
			jm_s7    <= (dq_j > DIV_QW'(JMAG_MAX)) ? JMAG_MAX : dq_j[MAG_W-1:0];
			skip_s7  <= dtag.skip;
			nx_s7    <= dtag.nx;
			ny_s7    <= dtag.ny;
			skip_s8  <= skip_s7;
			skip_s9  <= skip_s8;
			skip_s10 <= skip_s9;
		end
	end

	for (genvar k = 0; k < 6; k++) begin : g_lane
		logic signed [17:0] n;
		logic [MAG_W-1:0]   mag;
		logic [17:0]        an;
		logic               neg;
		logic [63:0]        full;

		assign n   = (k % 2 == 0) ? nx_s7 : ny_s7;
		assign mag = (k < 2) ? pa_s7 : ((k < 4) ? pb_s7 : jm_s7);
		assign neg = (k < 2);
		assign an  = n[17] ? 18'(-n) : 18'(n);
		// join the partial products and round at bit 15; the sum is kept to 64 bits,
		// so a full-scale normal times the clamped impulse wraps to zero
		assign full = (64'(hi_s8[k]) << 24) + 64'(lo_s8[k]) + 64'(ROUND_HALF);

		always_ff @(posedge clk) begin
			if (adv) begin
				lo_s8[k]   <= 42'(an) * 42'(mag[23:0]);
				hi_s8[k]   <= 42'(an) * 42'(mag[47:24]);
				sg_s8[k]   <= neg ^ n[17];
				r_s9[k]    <= 50'(full[63:16]);
				sg_s9[k]   <= sg_s8[k];
				res_s10[k] <= skip_s9 ? 32'd0 : sat_q16(r_s9[k], sg_s9[k]);
			end
		end
	end

	assign out_valid = v_s10;
	assign skipped   = skip_s10;
	assign shift_a_x = res_s10[0];
	assign shift_a_y = res_s10[1];
	assign shift_b_x = res_s10[2];
	assign shift_b_y = res_s10[3];
	assign impulse_x = res_s10[4];
	assign impulse_y = res_s10[5];

	// ---------------- checks ----------------
	// hold the input only while the output word is held
	`CIR_ASSERT(a_stall_link, in_stall == (out_valid && out_stall), "input stall not tied to output hold")
	// drop shift_a_x, shift_b_y and both impulse fields on a skipped contact
	`CIR_ASSERT(a_skip_zero, (out_valid && skipped) |-> (shift_a_x == 0 && shift_b_y == 0 && impulse_x == 0 && impulse_y == 0), "skipped contact with nonzero result")
	// the two bodies move apart along x
	`CIR_ASSERT(a_shift_sign, (out_valid && !skipped) |-> (shift_a_x == 0 || shift_b_x == 0 || shift_a_x[31] != shift_b_x[31]), "shifts of A and B agree in sign")
	// nothing leaves the pipe after an edge in reset
	`CIR_ASSERT_RST(a_reset_empty, !arst_n |=> !out_valid, "result word during reset")

endmodule
`default_nettype wire

/* tb/contact_impulse_resolver_test.sv */
`timescale 1ns / 1ps
module contact_impulse_resolver_test;
	import cir_pkg::*;

	// One contact word as offered on the input side.
	typedef struct {
		logic signed [31:0] vax, vay, vbx, vby;
		logic [30:0]        ima, imb;
		logic signed [17:0] nx, ny;
		logic [30:0]        depth;
	} contact_t;

	// One resolution word as seen on the output side.
	typedef struct {
		logic [31:0] sax, say, sbx, sby, jx, jy;
		logic        skip;
	} resolution_t;

	// Directed row: an expectation is typed in only where it is obvious.
	typedef struct {
		contact_t    c;
		bit          typed;
		resolution_t r;
	} row_t;

	localparam int LIMIT_CYCLES = 400000;
	localparam int DRAIN_CYCLES = 80;     // a little beyond the 63-stage pipe
	localparam int LONG_HOLD    = 250;    // well past the pipe depth, so the input backs up

	logic clk = 1'b0;
	logic arst_n = 1'b0;

	logic               in_valid = 1'b0;
	logic               in_stall;
	logic signed [31:0] vel_a_x = '0, vel_a_y = '0, vel_b_x = '0, vel_b_y = '0;
	logic [30:0]        inv_mass_a = '0, inv_mass_b = '0, depth = '0;
	logic signed [17:0] normal_x = '0, normal_y = '0;
	logic               out_valid;
	logic               out_stall = 1'b0;
	logic signed [31:0] shift_a_x, shift_a_y, shift_b_x, shift_b_y, impulse_x, impulse_y;
	logic               skipped;
	logic               psel = 1'b0, penable = 1'b0, pwrite = 1'b0;
	logic [2:0]         paddr = '0;
	logic [31:0]        pwdata = '0;
	logic [31:0]        prdata;
	logic               pready;

	contact_impulse_resolver dut (.*);

	always #5 clk = ~clk;

	// Predictor state and scoreboard.
	logic [16:0]  coef_model;
	resolution_t  pending_resolutions[$];
	int           errors = 0;
	int           cycles = 0;
	bit           quiet = 1'b0;       // no random idling on either side while set
	bit           hold_req = 1'b0;    // ask the receiver for one long hold-off
	int           hold_left = 0;
	int           rx_wait = 0;

	// Magnitude times normal, rounded half away from zero and clamped to 32 bits.
	// Arithmetic wraps at 64 bits exactly as the defined behaviour does.
	function automatic logic [31:0] scale_sat(longint n, longint unsigned mag, bit neg);
		longint unsigned an, r;
		bit s;
		an = (n < 0) ? longint'(-n) : n;
		s  = neg ^ (n < 0);
		r  = (an * mag + 64'h8000) >> 16;
		if (s)
			return (r > 64'h8000_0000) ? 32'h8000_0000 : 32'(-r);
		return (r > 64'h7FFF_FFFF) ? 32'h7FFF_FFFF : r[31:0];
	endfunction

	function automatic resolution_t resolve_contact(contact_t c);
		resolution_t     res;
		longint unsigned total, half, pa, pb, avn, vn16, jmag;
		longint          vn, nx, ny;
		res   = '{default: '0};
		total = longint'(c.ima) + longint'(c.imb);
		if (total == 0) begin
			res.skip = 1'b1;
			return res;
		end
		nx   = c.nx;
		ny   = c.ny;
		half = total >> 1;
		pa   = (longint'(c.depth) * c.ima + half) / total;
		pb   = (longint'(c.depth) * c.imb + half) / total;
		vn   = (longint'(c.vbx) - longint'(c.vax)) * nx + (longint'(c.vby) - longint'(c.vay)) * ny;
		jmag = 0;
		// approaching bodies only; separating contacts get no impulse
		if (vn < 0) begin
			avn  = -vn;
			vn16 = (avn + 64'h8000) >> 16;
			jmag = ((64'd65536 + coef_model) * vn16 + half) / total;
			if (jmag > 64'h8000_0000_0000)
				jmag = 64'h8000_0000_0000;
		end
		res.sax = scale_sat(nx, pa, 1'b1);
		res.say = scale_sat(ny, pa, 1'b1);
		res.sbx = scale_sat(nx, pb, 1'b0);
		res.sby = scale_sat(ny, pb, 1'b0);
		res.jx  = scale_sat(nx, jmag, 1'b0);
		res.jy  = scale_sat(ny, jmag, 1'b0);
		return res;
	endfunction

	task automatic report_mismatch(string what, logic [31:0] got, logic [31:0] exp);
		errors++;
		if (errors <= 40)
			$display("mismatch %s: got %h expected %h at cycle %0d", what, got, exp, cycles);
	endtask

	// Cycle limit: end the run if the pipe never drains.
	always @(posedge clk) begin
		cycles <= cycles + 1;
		if (cycles > LIMIT_CYCLES) begin
			$display("[FAIL] regression broken");
			$finish;
		end
	end

	// Receiver: hold out_stall for a drawn number of cycles after each word,
	// or for one long stretch on request so the pipe fills and backs up.
	always @(negedge clk) begin
		if (hold_req) begin
			hold_left = LONG_HOLD;
			hold_req = 1'b0;
		end
		if (hold_left > 0) begin
			hold_left--;
			out_stall <= 1'b1;
		end else if (rx_wait > 0) begin
			rx_wait--;
			out_stall <= 1'b1;
		end else begin
			out_stall <= 1'b0;
		end
	end

	// Monitor: compare every accepted result word with the oldest prediction.
	always @(posedge clk) begin
		resolution_t e;
		if (arst_n && out_valid && !out_stall) begin
			if (pending_resolutions.size() == 0) begin
				report_mismatch("unexpected word", {31'b0, skipped}, '0);
			end else begin
				e = pending_resolutions.pop_front();
				if (shift_a_x !== e.sax) report_mismatch("shift_a_x", shift_a_x, e.sax);
				if (shift_a_y !== e.say) report_mismatch("shift_a_y", shift_a_y, e.say);
				if (shift_b_x !== e.sbx) report_mismatch("shift_b_x", shift_b_x, e.sbx);
				if (shift_b_y !== e.sby) report_mismatch("shift_b_y", shift_b_y, e.sby);
				if (impulse_x !== e.jx)  report_mismatch("impulse_x", impulse_x, e.jx);
				if (impulse_y !== e.jy)  report_mismatch("impulse_y", impulse_y, e.jy);
				if (skipped !== e.skip)  report_mismatch("skipped", {31'b0, skipped}, {31'b0, e.skip});
			end
			rx_wait = quiet ? 0 : $urandom_range(0, 10);
		end
	end

	// Two-phase register write; also update the predictor's copy.
	task automatic reg_write(logic [2:0] addr, logic [31:0] data);
		psel    <= 1'b1;
		penable <= 1'b0;
		pwrite  <= 1'b1;
		paddr   <= addr;
		pwdata  <= data;
		@(negedge clk);
		penable <= 1'b1;
		@(posedge clk);
		while (!pready) @(posedge clk);
		if (addr == ADDR_RESTITUTION)
			coef_model = data[16:0];
		@(negedge clk);
		psel    <= 1'b0;
		penable <= 1'b0;
		pwrite  <= 1'b0;
	endtask

	// Offer one word, wait for acceptance, queue what it should produce.
	// Valid is lowered only when a gap follows, so it is never dropped and
	// raised within one step.
	task automatic send_contact(contact_t c, bit typed, resolution_t r);
		int gap;
		gap = quiet ? 0 : $urandom_range(0, 10);
		if (gap > 0) begin
			in_valid <= 1'b0;
			repeat (gap) @(negedge clk);
		end
		vel_a_x <= c.vax; vel_a_y <= c.vay;
		vel_b_x <= c.vbx; vel_b_y <= c.vby;
		inv_mass_a <= c.ima; inv_mass_b <= c.imb;
		normal_x <= c.nx; normal_y <= c.ny;
		depth <= c.depth;
		in_valid <= 1'b1;
		@(posedge clk);
		while (in_stall) @(posedge clk);
		pending_resolutions.push_back(typed ? r : resolve_contact(c));
		@(negedge clk);
	endtask

	// Sender pause: drop valid and hold until every expected word has come.
	task automatic drain_pipe();
		in_valid <= 1'b0;
		while (pending_resolutions.size() != 0) @(negedge clk);
	endtask

	function automatic contact_t mk(longint vax, longint vay, longint vbx, longint vby,
			longint ima, longint imb, longint nx, longint ny, longint dep);
		contact_t c;
		c.vax = 32'(vax); c.vay = 32'(vay); c.vbx = 32'(vbx); c.vby = 32'(vby);
		c.ima = 31'(ima); c.imb = 31'(imb); c.nx = 18'(nx); c.ny = 18'(ny);
		c.depth = 31'(dep);
		return c;
	endfunction

	// Random contact: mostly plausible physics, some raw bit patterns.
	function automatic contact_t random_contact();
		contact_t c;
		int unsigned mode;
		mode = $urandom_range(0, 9);
		c.vax = $urandom; c.vay = $urandom; c.vbx = $urandom; c.vby = $urandom;
		c.ima = 31'($urandom); c.imb = 31'($urandom);
		c.nx = 18'($urandom); c.ny = 18'($urandom);
		c.depth = 31'($urandom);
		if (mode >= 3) begin
			c.vax = $signed($urandom_range(0, 32'h0020_0000)) - 32'sh0010_0000;
			c.vay = $signed($urandom_range(0, 32'h0020_0000)) - 32'sh0010_0000;
			c.vbx = $signed($urandom_range(0, 32'h0020_0000)) - 32'sh0010_0000;
			c.vby = $signed($urandom_range(0, 32'h0020_0000)) - 32'sh0010_0000;
			c.ima = ($urandom_range(0, 7) == 0) ? 31'd0 : 31'($urandom_range(1, 32'h0004_0000));
			c.imb = ($urandom_range(0, 7) == 0) ? 31'd0 : 31'($urandom_range(1, 32'h0004_0000));
			c.nx  = 18'($signed($urandom_range(0, 131072)) - 65536);
			c.ny  = 18'($signed($urandom_range(0, 131072)) - 65536);
			c.depth = 31'($urandom_range(0, 32'h0002_0000));
		end
		return c;
	endfunction

	initial begin
		row_t        rows[$];
		resolution_t zero_res, skip_res, unit_a, unit_b;
		logic [16:0] coef_steps[4];
		int          n;

		coef_model = RESTITUTION_RESET;
		zero_res = '{default: '0};
		skip_res = zero_res;
		skip_res.skip = 1'b1;
		unit_a = zero_res;          // unit normal along x, equal masses, depth two
		unit_a.sax = 32'hFFFF_0000;
		unit_a.sbx = 32'h0001_0000;
		unit_b = zero_res;          // same along y, bodies already separating
		unit_b.say = 32'hFFFF_0000;
		unit_b.sby = 32'h0001_0000;

		// both immovable, fed with extreme values everywhere else
		rows.push_back('{mk(-2**31, 2**31-1, 2**31-1, -2**31, 0, 0, -131072, 131071, 2**31-1),
			1'b1, skip_res});
		rows.push_back('{mk(0, 0, 0, 0, 0, 0, 0, 0, 0), 1'b1, skip_res});
		rows.push_back('{mk(0, 0, 0, 0, 65536, 65536, 65536, 0, 131072), 1'b1, unit_a});
		rows.push_back('{mk(0, 0, 0, 65536, 65536, 65536, 0, 65536, 131072), 1'b1, unit_b});
		// approaching head-on, then the extremes of every field
		rows.push_back('{mk(65536, 0, -65536, 0, 65536, 65536, 65536, 0, 4096), 1'b0, zero_res});
		rows.push_back('{mk(2**31-1, 2**31-1, -2**31, -2**31, 1, 1, 131071, 131071, 2**31-1),
			1'b0, zero_res});
		rows.push_back('{mk(-2**31, -2**31, 2**31-1, 2**31-1, 1, 0, -131072, -131072, 2**31-1),
			1'b0, zero_res});
		rows.push_back('{mk(2**31-1, -2**31, -2**31, 2**31-1, 2**31-1, 2**31-1, -131072, 131071,
			2**31-1), 1'b0, zero_res});
		rows.push_back('{mk(2**31-1, 0, -2**31, 0, 0, 1, 131071, 0, 1), 1'b0, zero_res});
		// non-unit normals and a lopsided mass split
		rows.push_back('{mk(3 << 16, -5 << 16, -7 << 16, 2 << 16, 1 << 14, 9 << 16, 40000, -90000,
			3 << 16), 1'b0, zero_res});
		rows.push_back('{mk(0, 0, 0, 0, 2**31-1, 0, -65536, 65536, 2**31-1), 1'b0, zero_res});
		rows.push_back('{mk(-1, 1, 1, -1, 1, 2**31-1, 1, -1, 1), 1'b0, zero_res});

		// reset, then release away from the clock edge
		repeat (7) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;
		@(negedge clk);

		// directed part at the reset coefficient
		foreach (rows[i])
			send_contact(rows[i].c, rows[i].typed, rows[i].r);
		drain_pipe();

		// several coefficient settings, extremes included
		coef_steps[0] = 17'd0;
		coef_steps[1] = 17'd65536;
		coef_steps[2] = 17'h1FFFF;        // restitution above one
		coef_steps[3] = 17'($urandom_range(0, 65536));
		foreach (coef_steps[p]) begin
			reg_write(ADDR_RESTITUTION, {15'($urandom_range(0, 32'h7FFF)), coef_steps[p]});
			// an address past the register map must be ignored
			if (p == 1)
				reg_write(3'd4, $urandom);
			repeat (2) send_contact(rows[4 + p].c, 1'b0, zero_res);
			n = 0;
			while (n < 375) begin
				if (n % 50 == 0)
					quiet = ($urandom_range(0, 3) == 0);
				if (p == 2 && n == 100)
					hold_req = 1'b1;   // receiver backs off while words keep coming
				send_contact(random_contact(), 1'b0, zero_res);
				n++;
			end
			drain_pipe();
		end

		repeat (DRAIN_CYCLES) @(posedge clk);
		if (errors == 0 && pending_resolutions.size() == 0)
			$display("[ OK ] regression clean");
		else
			$display("[FAIL] regression broken");
		$finish;
	end

endmodule
